// ===== hdl/mcbd_pkg.sv =====
// shared constants and types for the multi-click button decoder
package mcbd_pkg;

   localparam int DEFAULT_FRAME_COUNT_BITS = 16;

   localparam int CFG_W      = 16;
   localparam int COUNT_W    = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   // register indexes, byte address is four times the index
   localparam logic [REG_IDX_W-1:0] REG_PRESS_MIN   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_PRESS_MAX   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RELEASE_MIN = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_RELEASE_MAX = 2'd3;

   localparam logic [CFG_W-1:0] PRESS_MIN_RESET   = 16'd10;
   localparam logic [CFG_W-1:0] PRESS_MAX_RESET   = 16'd100;
   localparam logic [CFG_W-1:0] RELEASE_MIN_RESET = 16'd8;
   localparam logic [CFG_W-1:0] RELEASE_MAX_RESET = 16'd36;

   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   localparam logic [COUNT_W-1:0] TOTAL_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic               count_valid;
      logic [COUNT_W-1:0] click_count;
   } rsp_word_type;

endpackage

// ===== hdl/mcbd_if.sv =====
// request and response channel interfaces of the multi-click button decoder
interface mcbd_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic pressed;

   modport source (output valid, output mode, output pressed, input ready);
   modport sink (input valid, input mode, input pressed, output ready);
endinterface

interface mcbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        count_valid;
   logic [mcbd_pkg::COUNT_W-1:0] click_count;

   modport source (output valid, output count_valid, output click_count, input ready);
   modport sink (input valid, input count_valid, input click_count, output ready);
endinterface

// ===== hdl/multi_click_button_decoder.sv =====
// multi-click button decoder: top level with frame counting, click windows and output buffer
//
// usage notes
// - req_chan takes one word per cycle while its ready is high: mode 0 is a frame sample
//   carrying the button level in pressed, mode 1 reads and clears the pending click count
// - rsp_chan returns exactly one word per request word, in order: count_valid and
//   click_count; a frame word reports the published total on the frame whose release
//   runs past release_max, otherwise zeros
// - the four window registers sit on the apb port at byte addresses 0, 4, 8 and 12;
//   write them only while no word is in flight
// - an accepted word's result is registered in the result register, or in the skid register
//   if that is full; frame counters, window compares and click total settle in one
//   combinational pass, and a new word is taken every clock while req_chan.ready is high
// - a two-entry output buffer (result register plus skid register) lets the block
//   take a new word while a result waits; req_chan.ready falls only once both are full
// - reset (synchronous, active high) clears all counters, the pending count and the
//   output buffer, and loads the window registers with their default values
// - a stalled receiver simply holds rsp_chan; no word is lost or repeated
module multi_click_button_decoder #(
   parameter int FRAME_COUNT_BITS = mcbd_pkg::DEFAULT_FRAME_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   mcbd_req_if.sink                          req_chan,
   mcbd_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mcbd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mcbd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mcbd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   // compare width covers both the frame counters and the 16 bit windows
   localparam int CMP_W = (FRAME_COUNT_BITS > mcbd_pkg::CFG_W) ?
                          FRAME_COUNT_BITS : mcbd_pkg::CFG_W;
   localparam logic [FRAME_COUNT_BITS-1:0] FRAME_MAX = {FRAME_COUNT_BITS{1'b1}};

   // window registers
   logic [mcbd_pkg::CFG_W-1:0] press_min_ff, press_max_ff;
   logic [mcbd_pkg::CFG_W-1:0] release_min_ff, release_max_ff;

   // gesture state
   logic [FRAME_COUNT_BITS-1:0] press_frames_ff, press_frames_in;
   logic [FRAME_COUNT_BITS-1:0] release_frames_ff, release_frames_in;
   logic [FRAME_COUNT_BITS-1:0] last_press_ff, last_press_in;
   logic [mcbd_pkg::COUNT_W-1:0] click_total_ff, click_total_in;
   logic                         click_taken_ff, click_taken_in;
   logic [mcbd_pkg::COUNT_W-1:0] pending_count_ff, pending_count_in;
   logic                         pending_valid_ff, pending_valid_in;

   // output buffer: result register and skid register
   mcbd_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                   out_valid_ff, out_valid_in;
   mcbd_pkg::rsp_word_type skid_word_ff, skid_word_in;
   logic                   skid_valid_ff, skid_valid_in;

   logic                              req_take;
   logic                              rsp_take;
   logic                              csr_write;
   logic [mcbd_pkg::REG_IDX_W-1:0]    csr_idx;
   mcbd_pkg::rsp_word_type            new_word;

   // window compare helpers
   logic [CMP_W-1:0] last_cmp, release_cmp;
   logic             press_ok, release_ok, click_hit, publish;
   logic [mcbd_pkg::COUNT_W-1:0] total_after;

   // ---------------------------------------------------------------- apb port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[mcbd_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         press_min_ff   <= mcbd_pkg::PRESS_MIN_RESET;
         press_max_ff   <= mcbd_pkg::PRESS_MAX_RESET;
         release_min_ff <= mcbd_pkg::RELEASE_MIN_RESET;
         release_max_ff <= mcbd_pkg::RELEASE_MAX_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            mcbd_pkg::REG_PRESS_MIN:   press_min_ff   <= pwdata[mcbd_pkg::CFG_W-1:0];
            mcbd_pkg::REG_PRESS_MAX:   press_max_ff   <= pwdata[mcbd_pkg::CFG_W-1:0];
            mcbd_pkg::REG_RELEASE_MIN: release_min_ff <= pwdata[mcbd_pkg::CFG_W-1:0];
            mcbd_pkg::REG_RELEASE_MAX: release_max_ff <= pwdata[mcbd_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mcbd_pkg::REG_PRESS_MIN:   prdata = mcbd_pkg::CSR_DATA_W'(press_min_ff);
         mcbd_pkg::REG_PRESS_MAX:   prdata = mcbd_pkg::CSR_DATA_W'(press_max_ff);
         mcbd_pkg::REG_RELEASE_MIN: prdata = mcbd_pkg::CSR_DATA_W'(release_min_ff);
         mcbd_pkg::REG_RELEASE_MAX: prdata = mcbd_pkg::CSR_DATA_W'(release_max_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   // a new word is taken as long as the skid register is free
   assign req_chan.ready = !skid_valid_ff;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;

   // ---------------------------------------------------------------- gesture logic
   always_comb begin
      press_frames_in   = press_frames_ff;
      release_frames_in = release_frames_ff;
      last_press_in     = last_press_ff;
      click_total_in    = click_total_ff;
      click_taken_in    = click_taken_ff;
      pending_count_in  = pending_count_ff;
      pending_valid_in  = pending_valid_ff;
      new_word          = '0;

      // frame counters, saturating
      if (req_chan.pressed) begin
         if (press_frames_ff != FRAME_MAX) begin
            press_frames_in = press_frames_ff + 1'b1;
         end
         release_frames_in = '0;
         click_taken_in    = 1'b0;
      end else begin
         if (press_frames_ff != '0) begin
            last_press_in   = press_frames_ff;
            press_frames_in = '0;
         end
         if (release_frames_ff != FRAME_MAX) begin
            release_frames_in = release_frames_ff + 1'b1;
         end
      end

      // one click per release once both lengths sit inside their windows
      last_cmp    = CMP_W'(last_press_in);
      release_cmp = CMP_W'(release_frames_in);
      press_ok    = (last_cmp >= CMP_W'(press_min_ff)) && (last_cmp <= CMP_W'(press_max_ff));
      release_ok  = (release_cmp >= CMP_W'(release_min_ff)) &&
                    (release_cmp <= CMP_W'(release_max_ff));
      click_hit   = press_ok && release_ok && !click_taken_in;

      total_after = click_total_ff;
      if (click_hit && (click_total_ff != mcbd_pkg::TOTAL_MAX)) begin
         total_after = click_total_ff + 1'b1;
      end

      // long release closes the gesture and publishes a nonzero total
      publish = (release_cmp > CMP_W'(release_max_ff)) && (total_after != '0);

      if (req_chan.mode == mcbd_pkg::MODE_READ) begin
         // read word: counters untouched, pending count handed out and cleared
         press_frames_in       = press_frames_ff;
         release_frames_in     = release_frames_ff;
         last_press_in         = last_press_ff;
         click_total_in        = click_total_ff;
         click_taken_in        = click_taken_ff;
         new_word.count_valid  = pending_valid_ff;
         new_word.click_count  = pending_valid_ff ? pending_count_ff : '0;
         pending_count_in      = '0;
         pending_valid_in      = 1'b0;
      end else begin
         click_taken_in = click_taken_in || click_hit;
         click_total_in = total_after;
         if (publish) begin
            pending_count_in     = total_after;
            pending_valid_in     = 1'b1;
            new_word.count_valid = 1'b1;
            new_word.click_count = total_after;
            click_total_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_frames_ff   <= '0;
         release_frames_ff <= '0;
         last_press_ff     <= '0;
         click_total_ff    <= '0;
         click_taken_ff    <= 1'b0;
         pending_count_ff  <= '0;
         pending_valid_ff  <= 1'b0;
      end else if (req_take) begin
         press_frames_ff   <= press_frames_in;
         release_frames_ff <= release_frames_in;
         last_press_ff     <= last_press_in;
         click_total_ff    <= click_total_in;
         click_taken_ff    <= click_taken_in;
         pending_count_ff  <= pending_count_in;
         pending_valid_ff  <= pending_valid_in;
      end
   end

   // ---------------------------------------------------------------- output buffer
   always_comb begin
      out_word_in   = out_word_ff;
      out_valid_in  = out_valid_ff;
      skid_word_in  = skid_word_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            // skid word moves up, no new word can arrive this cycle
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_word_in  = new_word;
            out_valid_in = req_take;
         end
      end else if (req_take) begin
         if (!out_valid_ff) begin
            out_word_in  = new_word;
            out_valid_in = 1'b1;
         end else begin
            skid_word_in  = new_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.count_valid = out_word_ff.count_valid;
   assign rsp_chan.click_count = out_word_ff.click_count;

   // ---------------------------------------------------------------- assertions
   // skid register only fills behind a full result register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while result register empty");

   // a reported count is never zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.count_valid) |-> (rsp_chan.click_count != '0))
      else $error("reported click count is zero");

   // no count reported means a zero count field
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.count_valid) |-> (rsp_chan.click_count == '0))
      else $error("click count set without count_valid");

   // a pressed frame restarts the release count
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_chan.mode == mcbd_pkg::MODE_FRAME) && req_chan.pressed)
      |=> (release_frames_ff == '0))
      else $error("release count not cleared after a pressed frame");

endmodule

// ===== tb/sv/mcbd_checker.sv =====
// checker for the multi-click button decoder: watches the channels, predicts each word, compares
module mcbd_checker
   import mcbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_mode,
   input  logic                  req_pressed,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_count_valid,
   input  logic [COUNT_W-1:0]    rsp_click_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int FB = DEFAULT_FRAME_COUNT_BITS;
   localparam logic [FB-1:0] FRAME_MAX = {FB{1'b1}};

   // window registers as the block should hold them
   logic [CFG_W-1:0] win_press_min, win_press_max, win_release_min, win_release_max;

   // gesture state
   logic [FB-1:0]      press_run, release_run, last_press_len;
   logic [COUNT_W-1:0] gesture_clicks, held_count;
   logic               click_done, held_valid;

   rsp_word_type decoded_words[$];
   rsp_word_type oldest;

   function automatic logic [FB-1:0] frame_bump(logic [FB-1:0] v);
      return (v == FRAME_MAX) ? v : v + 1'b1;
   endfunction

   // advances the gesture state by one word and returns the word the block owes for it
   function automatic rsp_word_type decode_word(logic mode, logic pressed);
      rsp_word_type w;
      w = '0;
      if (mode == MODE_READ) begin
         w.count_valid = held_valid;
         w.click_count = held_valid ? held_count : '0;
         held_valid = 1'b0;
         held_count = '0;
         return w;
      end
      if (pressed) begin
         press_run = frame_bump(press_run);
         release_run = '0;
         click_done = 1'b0;
      end else begin
         if (press_run != 0) begin
            last_press_len = press_run;
            press_run = '0;
         end
         release_run = frame_bump(release_run);
      end
      if (last_press_len >= win_press_min && last_press_len <= win_press_max &&
          release_run >= win_release_min && release_run <= win_release_max && !click_done) begin
         if (gesture_clicks != TOTAL_MAX)
            gesture_clicks = gesture_clicks + 1'b1;
         click_done = 1'b1;
      end
      if (release_run > win_release_max && gesture_clicks != 0) begin
         held_count = gesture_clicks;
         held_valid = 1'b1;
         w.count_valid = 1'b1;
         w.click_count = gesture_clicks;
         gesture_clicks = '0;
      end
      return w;
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         win_press_min = PRESS_MIN_RESET;
         win_press_max = PRESS_MAX_RESET;
         win_release_min = RELEASE_MIN_RESET;
         win_release_max = RELEASE_MAX_RESET;
         press_run = '0;
         release_run = '0;
         last_press_len = '0;
         gesture_clicks = '0;
         click_done = 1'b0;
         held_count = '0;
         held_valid = 1'b0;
         decoded_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_words.size() == 0) begin
               fail_count++;
               $display("%0t: word with none predicted, expected none, actual count_valid %0b click_count %0d",
                        $time, rsp_count_valid, rsp_click_count);
            end else begin
               oldest = decoded_words.pop_front();
               if (rsp_count_valid !== oldest.count_valid) begin
                  fail_count++;
                  $display("%0t: count_valid expected %0b actual %0b",
                           $time, oldest.count_valid, rsp_count_valid);
               end
               if (rsp_click_count !== oldest.click_count) begin
                  fail_count++;
                  $display("%0t: click_count expected %0d actual %0d",
                           $time, oldest.click_count, rsp_click_count);
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_PRESS_MIN:   win_press_min = pwdata[CFG_W-1:0];
               REG_PRESS_MAX:   win_press_max = pwdata[CFG_W-1:0];
               REG_RELEASE_MIN: win_release_min = pwdata[CFG_W-1:0];
               REG_RELEASE_MAX: win_release_max = pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            decoded_words.push_back(decode_word(req_mode, req_pressed));
      end
      outstanding = decoded_words.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the multi-click button decoder testbench: clock, reset, stimulus and verdict
module tb_top;
   import mcbd_pkg::*;

   // worst case is every word behind a long request gap and a long response stall
   localparam int CYCLE_LIMIT = 1_000_000;
   // gesture lengths are clipped so wide windows do not make the run crawl
   localparam int LEN_CAP = 120;

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mcbd_req_if req_if ();
   mcbd_rsp_if rsp_if ();

   int fail_count;
   int outstanding;
   int cycle_count;
   int words_sent;
   int read_pct;
   int stall_left;
   bit idle_on;

   // stimulus copy of the windows, only used to shape gestures
   int sh_press_min, sh_press_max, sh_release_min, sh_release_max;

   multi_click_button_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mcbd_checker click_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_mode        (req_if.mode),
      .req_pressed     (req_if.pressed),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_count_valid (rsp_if.count_valid),
      .rsp_click_count (rsp_if.click_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** multi_click_button_decoder: FAILED **");
         $finish;
      end
   end

   // gap length for either side: mostly none or short, now and then a long one
   function automatic int gap_cycles();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver side: ready changes only at the falling edge, one assignment per edge
   initial begin
      rsp_if.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 30)
            stall_left = gap_cycles();
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // one word on the request channel; valid stays high between back-to-back words
   task automatic send_word(input logic mode, input logic pressed);
      int gap;
      gap = gap_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.mode <= mode;
      req_if.pressed <= pressed;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      words_sent++;
   endtask

   // a run of frames at one level, with the odd read slipped in when asked for
   task automatic send_frames(input logic level, input int len);
      for (int i = 0; i < len; i++) begin
         if (read_pct > 0 && $urandom_range(0, 99) < read_pct)
            send_word(MODE_READ, 1'($urandom_range(0, 1)));
         send_word(MODE_FRAME, level);
      end
   endtask

   // wait until every predicted word has come back, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // new windows, only ever written with the block idle
   task automatic set_windows(input int pmin, input int pmax, input int rmin, input int rmax);
      drain();
      csr_write(REG_PRESS_MIN, CFG_W'(pmin));
      csr_write(REG_PRESS_MAX, CFG_W'(pmax));
      csr_write(REG_RELEASE_MIN, CFG_W'(rmin));
      csr_write(REG_RELEASE_MAX, CFG_W'(rmax));
      sh_press_min = pmin;
      sh_press_max = pmax;
      sh_release_min = rmin;
      sh_release_max = rmax;
   endtask

   // a length around a window: mostly inside, sometimes just off either edge
   function automatic int pick_len(input int lo, input int hi);
      int l, h, r;
      l = (lo > LEN_CAP) ? LEN_CAP : lo;
      h = (hi > LEN_CAP) ? LEN_CAP : hi;
      if (l < 1)
         l = 1;
      if (h < l)
         h = l;
      r = $urandom_range(0, 99);
      if (r < 15)
         return (l > 1) ? l - 1 : l;
      if (r < 30)
         return h + 1;
      return $urandom_range(l, h);
   endfunction

   // mostly well-formed multi-click gestures, plus noise bursts and stray reads
   task automatic run_gestures(input int n_words);
      int stop_at, clicks, r;
      stop_at = words_sent + n_words;
      read_pct = 5;
      while (words_sent < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 78) begin
            clicks = $urandom_range(1, 4);
            for (int c = 0; c < clicks; c++) begin
               send_frames(1'b1, pick_len(sh_press_min, sh_press_max));
               if (c < clicks - 1)
                  send_frames(1'b0, pick_len(sh_release_min, sh_release_max));
            end
            // closing release, usually long enough to publish
            send_frames(1'b0, pick_len(sh_release_max + 1, sh_release_max + 3));
         end else if (r < 90) begin
            repeat ($urandom_range(1, 8))
               send_word(MODE_FRAME, 1'($urandom_range(0, 1)));
         end else begin
            send_word(MODE_READ, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.mode = MODE_FRAME;
      req_if.pressed = 1'b0;
      words_sent = 0;
      read_pct = 0;
      idle_on = 1'b0;
      sh_press_min = PRESS_MIN_RESET;
      sh_press_max = PRESS_MAX_RESET;
      sh_release_min = RELEASE_MIN_RESET;
      sh_release_max = RELEASE_MAX_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default windows straight out of reset
      run_gestures(100);

      // tight windows for the directed part: one-frame presses and releases count
      set_windows(1, 2, 1, 2);
      read_pct = 0;
      idle_on = 1'b1;
      // read, clearing any count left pending by the random part
      send_word(MODE_READ, 1'b1);
      // single click, published when the release runs past its maximum
      send_frames(1'b1, 1);
      send_frames(1'b0, 3);
      // press too long, no click and nothing published
      send_frames(1'b1, 3);
      send_frames(1'b0, 3);
      // double click published over the unread single click
      send_frames(1'b1, 2);
      send_frames(1'b0, 1);
      send_frames(1'b1, 1);
      send_frames(1'b0, 3);
      // read returns the newer count, a second read finds it cleared
      send_word(MODE_READ, 1'b0);
      send_word(MODE_READ, 1'b1);
      // long release with an empty total publishes nothing
      send_frames(1'b0, 2);

      // click total saturates at its maximum
      idle_on = 1'b0;
      repeat (260) begin
         send_frames(1'b1, 1);
         send_frames(1'b0, 1);
      end
      send_frames(1'b0, 2);
      send_word(MODE_READ, 1'b0);
      run_gestures(150);

      // zero minimums: clicks can count on the first release frame or during a press
      set_windows(0, 3, 0, 5);
      run_gestures(120);

      // both windows empty, no click ever counts
      set_windows(5, 0, 6, 2);
      run_gestures(50);

      // release maximum of zero publishes on the first released frame
      set_windows(2, 65535, 0, 0);
      run_gestures(80);

      // a few random small window settings
      repeat (3) begin
         sh_press_min = $urandom_range(1, 6);
         set_windows(sh_press_min, sh_press_min + $urandom_range(0, 8) - 1,
                     $urandom_range(0, 5), $urandom_range(5, 15));
         run_gestures(40);
      end

      drain();
      if (fail_count == 0) begin
         $display("** multi_click_button_decoder: PASSED **");
      end else begin
         $display("** multi_click_button_decoder: FAILED **");
      end
      $finish;
   end

endmodule
